// File: rtl/pid_with_filtered_error_macros.svh
// ----------------------------------------------------------------------------
// pid_with_filtered_error_macros
// Assertion macros used by the sequencer pwfe_ctrl of the PID block.
// ----------------------------------------------------------------------------
`ifndef PID_WITH_FILTERED_ERROR_MACROS_SVH
`define PID_WITH_FILTERED_ERROR_MACROS_SVH
`ifndef ASSERT_OFF
`define PWFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("pwfe check");
`define PWFE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pwfe check");
`else
`define PWFE_ASSERT(lbl, clk, rstn, prop)
`define PWFE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/pwfe_pkg.sv
// ----------------------------------------------------------------------------
// pwfe_pkg
// Types, widths and codes of the filtered-error PID block.
// ----------------------------------------------------------------------------
`default_nettype none
package pwfe_pkg;
  localparam int FILTER_LEN_DEF = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd6;

  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_SEPARATE = 2'd1;
  localparam logic [1:0] MODE_WEIGHT = 2'd2;
  localparam logic [1:0] MODE_FULL_ALT = 2'd3;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;
  localparam logic [1:0] MUL_W = 2'd3;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD = 2'd2;

  localparam int DIV_W = 32;
  localparam int DVS_W = 16;

  typedef struct packed {
    logic       cap;
    logic       win_upd;
    logic       div_start;
    logic       e_fix;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       int_upd;
    logic       fin;
  } pwfe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic mode_weight;
  } pwfe_status_t;
endpackage
`default_nettype wire

// File: rtl/pwfe_if.sv
// ----------------------------------------------------------------------------
// pwfe_if
// Valid/ready channels of the PID block: step input and drive result.
// ----------------------------------------------------------------------------
`default_nettype none
interface pwfe_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] target;
  logic signed [15:0] measured;
  modport source (output valid, output cmd, output target, output measured, input ready);
  modport sink (input valid, input cmd, input target, input measured, output ready);
endinterface

interface pwfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               saturated;
  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/pid_with_filtered_error.sv
// ----------------------------------------------------------------------------
// pid_with_filtered_error
// PID step with deadband, moving-average error, integral separation or
// weighting, anti-windup clamp and saturated output.
//
//   channel  dir  payload                    transaction
//   in_ch    in   cmd, target, measured      valid & ready
//   out_ch   out  drive, saturated           valid & ready
//   cfg      in   cfg_we, cfg_idx, cfg_data  cfg_we
//
// A compute step runs S_LOAD, S_EFIX, S_INT, S_MP, S_MI, S_MD, S_MF, S_FIN;
// in weighting mode S_M2, S_D2S and S_D2W, where the serial divider works,
// lie between S_EFIX and S_INT. A clear step goes straight to S_FIN.
// One step is in flight at a time. The result register holds while out_ch
// stalls; the next step is accepted meanwhile and waits only in S_FIN.
// Synchronous active-low reset clears the window, sums and integral.
// ----------------------------------------------------------------------------
`default_nettype none
module pid_with_filtered_error
  import pwfe_pkg::*;
#(
  parameter int FILTER_LEN = FILTER_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pwfe_in_if.sink                    in_ch,
  pwfe_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  pwfe_cmd_t    cmd;
  pwfe_status_t status;

  pwfe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_cmd(in_ch.cmd),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  pwfe_dp #(.FILTER_LEN(FILTER_LEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_cmd(in_ch.cmd), .in_target(in_ch.target),
    .in_measured(in_ch.measured), .cmd(cmd), .status(status),
    .out_drive(out_ch.drive), .out_saturated(out_ch.saturated)
  );
endmodule
`default_nettype wire

// File: rtl/pwfe_div.sv
// ----------------------------------------------------------------------------
// pwfe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwfe_div
  import pwfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);
  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// File: rtl/pwfe_dp.sv
// ----------------------------------------------------------------------------
// pwfe_dp
// Datapath: configuration, error window, divider, shared multiplier,
// integral and output register. FILTER_LEN is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none
module pwfe_dp
  import pwfe_pkg::*;
#(
  parameter int FILTER_LEN = FILTER_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_cmd,
  input  wire logic signed [15:0]    in_target,
  input  wire logic signed [15:0]    in_measured,
  input  wire pwfe_cmd_t             cmd,
  output pwfe_status_t               status,
  output logic signed [15:0]         out_drive,
  output logic                       out_saturated
);
  localparam int SW = 17 + $clog2(FILTER_LEN);
  localparam int FL_SH = $clog2(FILTER_LEN);

  logic signed [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [14:0]        drive_limit_r, dead_zone_r;
  logic [15:0]        int_window_r;
  logic [1:0]         int_mode_r;

  logic               clr_r;
  logic signed [15:0] tgt_r, meas_r;
  logic signed [16:0] win_r [FILTER_LEN];
  logic signed [SW-1:0] sum_r;
  logic signed [16:0] e_r, prev_r;
  logic signed [18:0] integ_r;
  logic signed [37:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [15:0] drive_r;
  logic               sat_r;

  logic signed [16:0] raw, raw_db, d_abs;
  logic signed [SW-1:0] sum_sh;
  logic [DIV_W-1:0]   dv_dividend;
  logic [DVS_W-1:0]   dv_divisor;
  logic               dv_busy, dv_done;
  logic [DIV_W-1:0]   dv_q;
  logic [15:0]        e_abs, w_minus;
  logic               e_in_win;
  logic signed [17:0] q_s;
  logic signed [16:0] inc;
  logic signed [20:0] itmp, lim3;
  logic signed [17:0] diff;
  logic signed [17:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [31:0] shifted, lim_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'sd26;
      gain_i_r <= 16'sd26;
      gain_d_r <= 16'sd26;
      drive_limit_r <= 15'd512;
      int_window_r <= 16'd400;
      int_mode_r <= MODE_SEPARATE;
      dead_zone_r <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_P: gain_p_r <= cfg_data;
        REG_GAIN_I: gain_i_r <= cfg_data;
        REG_GAIN_D: gain_d_r <= cfg_data;
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_data[14:0];
        REG_INT_WINDOW: int_window_r <= cfg_data;
        REG_INT_MODE: int_mode_r <= cfg_data[1:0];
        REG_DEAD_ZONE: dead_zone_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw = 17'(tgt_r) - 17'(meas_r);
    d_abs = raw[16] ? -raw : raw;
    raw_db = (d_abs < $signed({2'b00, dead_zone_r})) ? '0 : raw;
    sum_sh = sum_r >>> FL_SH;
    e_abs = e_r[16] ? 16'(-e_r) : 16'(e_r);
    e_in_win = e_abs < int_window_r;
    w_minus = int_window_r - e_abs;
    dv_dividend = prod_r[DIV_W-1:0];
    dv_divisor = int_window_r;
    q_s = $signed({2'b00, dv_q[15:0]});
    case (int_mode_r)
      MODE_SEPARATE: inc = e_in_win ? e_r : '0;
      MODE_WEIGHT: inc = !e_in_win ? '0 : (e_r[16] ? 17'(-q_s) : 17'(q_s));
      default: inc = e_r;
    endcase
    lim3 = $signed(21'(drive_limit_r) * 21'd3);
    itmp = 21'(integ_r) + 21'(inc);
    if (itmp > lim3) itmp = lim3;
    else if (itmp < -lim3) itmp = -lim3;
    diff = 18'(e_r) - 18'(prev_r);
    case (cmd.mul_sel)
      MUL_P: begin mul_a = 18'(gain_p_r); mul_b = 20'(e_r); end
      MUL_I: begin mul_a = 18'(gain_i_r); mul_b = 20'(integ_r); end
      MUL_D: begin mul_a = 18'(gain_d_r); mul_b = 20'(diff); end
      default: begin
        mul_a = $signed({2'b00, w_minus});
        mul_b = $signed({4'b0000, e_abs});
      end
    endcase
    shifted = acc_r[39:8];
    lim_s = $signed({17'd0, drive_limit_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_LEN; i++) win_r[i] <= '0;
      sum_r <= '0;
      integ_r <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.win_upd) begin
        for (int i = 0; i < FILTER_LEN - 1; i++) win_r[i] <= win_r[i+1];
        win_r[FILTER_LEN-1] <= raw_db;
        sum_r <= sum_r - SW'(win_r[0]) + SW'(raw_db);
      end
      if (cmd.int_upd) integ_r <= itmp[18:0];
      if (cmd.fin) begin
        if (clr_r) begin
          integ_r <= '0;
          prev_r <= '0;
        end else begin
          prev_r <= e_r;
        end
      end
    end
    if (cmd.cap) begin
      clr_r <= (in_cmd == CMD_CLEAR);
      tgt_r <= in_target;
      meas_r <= in_measured;
    end
    if (cmd.e_fix) e_r <= sum_sh[16:0];
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= 40'(prod_r);
      ACC_ADD: acc_r <= acc_r + 40'(prod_r);
      default: ;
    endcase
    if (cmd.fin) begin
      if (clr_r) begin
        drive_r <= '0;
        sat_r <= 1'b0;
      end else if (shifted > lim_s) begin
        drive_r <= 16'(lim_s);
        sat_r <= 1'b1;
      end else if (shifted < -lim_s) begin
        drive_r <= 16'(-lim_s);
        sat_r <= 1'b1;
      end else begin
        drive_r <= shifted[15:0];
        sat_r <= 1'b0;
      end
    end
  end

  pwfe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dv_dividend),
    .divisor(dv_divisor), .busy(dv_busy), .done(dv_done), .quotient(dv_q)
  );

  assign status.div_done = dv_done;
  assign status.div_busy = dv_busy;
  assign status.mode_weight = (int_mode_r == MODE_WEIGHT);
  assign out_drive = drive_r;
  assign out_saturated = sat_r;
endmodule
`default_nettype wire

// File: rtl/pwfe_ctrl.sv
// ----------------------------------------------------------------------------
// pwfe_ctrl
// Sequencer of one control step and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pid_with_filtered_error_macros.svh"
module pwfe_ctrl
  import pwfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire logic   in_cmd,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  input  pwfe_status_t status,
  output pwfe_cmd_t   cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_EFIX = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_D2S  = 4'd6;
  localparam logic [3:0] S_D2W  = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_MP   = 4'd9;
  localparam logic [3:0] S_MI   = 4'd10;
  localparam logic [3:0] S_MD   = 4'd11;
  localparam logic [3:0] S_MF   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       slot_free;

  assign slot_free = !ovalid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mul_sel = MUL_P;
    cmd.acc_op = ACC_HOLD;
    ovalid_nxt = ovalid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cmd.cap = in_valid;
        if (in_valid) state_nxt = (in_cmd == CMD_CLEAR) ? S_FIN : S_LOAD;
      end
      S_LOAD: begin
        cmd.win_upd = 1'b1;
        state_nxt = S_EFIX;
      end
      S_EFIX: begin
        cmd.e_fix = 1'b1;
        state_nxt = status.mode_weight ? S_M2 : S_INT;
      end
      S_M2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_W;
        state_nxt = S_D2S;
      end
      S_D2S: begin
        cmd.div_start = 1'b1;
        state_nxt = S_D2W;
      end
      S_D2W: begin
        if (status.div_done) state_nxt = S_INT;
      end
      S_INT: begin
        cmd.int_upd = 1'b1;
        state_nxt = S_MP;
      end
      S_MP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt = S_MI;
      end
      S_MI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_op = ACC_LOAD;
        state_nxt = S_MD;
      end
      S_MD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_op = ACC_ADD;
        state_nxt = S_MF;
      end
      S_MF: begin
        cmd.acc_op = ACC_ADD;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  `PWFE_ASSERT(a_fin_slot, clk, rst_n, cmd.fin |-> slot_free)
  `PWFE_ASSERT(a_one_item, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `PWFE_ASSERT(a_rose_fin, clk, rst_n, $rose(ovalid_r) |-> $past(state_r) == S_FIN)
  `PWFE_ASSERT(a_div_free, clk, rst_n, cmd.div_start |-> !status.div_busy)
endmodule
`default_nettype wire
